@@ rtl/lzpht_pkg.sv @@
// Shared types and codes for the LZ phrase height tracker.
// No dependencies; used by lzpht_ctrl, lzpht_dp and the core top level.
package lzpht_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SRC  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;  // latch phrase, run checks
    logic adv;   // emit one copied character
    logic lit;   // emit trailing literal, close phrase
    logic err;   // emit error result, close phrase
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic st_ok;
    logic is_lit;
    logic last_copy;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/lz_phrase_height_tracker_core.sv @@
// Top level of the LZ phrase height tracker.
// Depends on lzpht_pkg, lzpht_ctrl and lzpht_dp.
//
//  channel  direction  handshake               payload
//  in_      input      in_valid / in_ready     source_position, phrase_length, end_of_text
//  out_     output     out_valid / out_ready   text_position, height, last, status
//
// Sequence: an accepted phrase of length L that passes its checks is accepted,
//   its first store read is issued, then it gives one result per cycle while
//   out_ready is held high; a failing phrase gives a single error result. The height store's single read and
//   single write per produced character set the one-result-per-cycle pace.
// Reset: synchronous, active low; clears text end, sequencer and out_valid.
//   The height store is not cleared, only written entries are ever read.
// Stalls: out_ready low holds the sequencer; the store read is simply
//   reissued. in_ready rises once the final result is in the output register.
module lz_phrase_height_tracker_core #(
  parameter int TEXT_DEPTH     = 65536,
  parameter int MAX_PHRASE_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_source_position,
  input  logic [15:0] in_phrase_length,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_text_position,
  output logic [15:0] out_height,
  output logic        out_last,
  output logic [1:0]  out_status
);

  // command and status between sequencer and datapath
  lzpht_pkg::cmd_t cmd;
  lzpht_pkg::sts_t sts;

  // sequencer: idle, decide (first read in flight), copy run, trailing literal,
  // error result
  lzpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: checks at accept, height store with one-entry bypass for a
  // source one position behind the write, and the output register that
  // frees the sequencer while a transaction waits on out_ready
  lzpht_dp #(
    .TEXT_DEPTH     (TEXT_DEPTH),
    .MAX_PHRASE_LEN (MAX_PHRASE_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_source_position (in_source_position),
    .in_phrase_length   (in_phrase_length),
    .in_end_of_text     (in_end_of_text),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_text_position  (out_text_position),
    .out_height         (out_height),
    .out_last           (out_last),
    .out_status         (out_status),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

@@ rtl/lzpht_ctrl.sv @@
// Phrase sequencer for the LZ phrase height tracker.
// Depends on lzpht_pkg (cmd_t, sts_t).
module lzpht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lzpht_pkg::sts_t   sts,
  output lzpht_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RUN,
    S_LIT,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // first source read is in flight this cycle
        if (!sts.st_ok) begin
          state_nxt = S_ERR;
        end else if (sts.is_lit) begin
          state_nxt = S_LIT;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.out_free) begin
          cmd.adv = 1'b1;
          if (sts.last_copy) begin
            state_nxt = S_LIT;
          end
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.lit   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.err   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  a_adv_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.adv || cmd.lit || cmd.err) |-> sts.out_free)
    else $error("result issued while output register busy");

  a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.lit || cmd.err) |=> in_ready)
    else $error("phrase closed but input not reopened");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("input open outside idle");

endmodule

@@ rtl/lzpht_dp.sv @@
// Datapath for the LZ phrase height tracker: checks, height store, forwarding,
// text end register and the output register. Depends on lzpht_pkg.
module lzpht_dp #(
  parameter int TEXT_DEPTH     = 65536,
  parameter int MAX_PHRASE_LEN = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       in_source_position,
  input  logic [15:0]       in_phrase_length,
  input  logic              in_end_of_text,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_text_position,
  output logic [15:0]       out_height,
  output logic              out_last,
  output logic [1:0]        out_status,
  input  lzpht_pkg::cmd_t   cmd,
  output lzpht_pkg::sts_t   sts
);

  localparam int AW  = $clog2(TEXT_DEPTH);
  localparam int TEW = AW + 1;
  localparam int LW  = $clog2(MAX_PHRASE_LEN + 1);
  localparam int CW  = ((TEW > 16) ? TEW : 16) + 1;

  logic [15:0] mem [TEXT_DEPTH];

  logic [TEW-1:0] text_end_r;
  logic [AW-1:0]  src_r, start_r;
  logic [LW-1:0]  len_r, j_r, j_nxt;
  logic           eot_r;
  logic [1:0]     status_r, status_nxt;
  logic [15:0]    rdata_r, fwd_val_r;
  logic           fwd_r;
  logic           out_valid_r;
  logic [15:0]    out_pos_r, out_height_r;
  logic           out_last_r;
  logic [1:0]     out_status_r;

  logic [CW-1:0]  end_sum;
  logic           len_bad, full, src_bad;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [15:0]    h_src, h_cpy;
  logic           self_ref;

  // phrase checks, priority: length, capacity, source
  always_comb begin
    end_sum = CW'(text_end_r) + CW'(in_phrase_length);
    len_bad = (in_phrase_length == 16'd0) || (in_phrase_length > 16'(MAX_PHRASE_LEN));
    full    = end_sum > CW'(TEXT_DEPTH);
    src_bad = (in_phrase_length >= 16'd2) &&
              (CW'(in_source_position) >= CW'(text_end_r));
    if (len_bad) begin
      status_nxt = lzpht_pkg::ST_LONG;
    end else if (full) begin
      status_nxt = lzpht_pkg::ST_FULL;
    end else if (src_bad) begin
      status_nxt = lzpht_pkg::ST_SRC;
    end else begin
      status_nxt = lzpht_pkg::ST_OK;
    end
  end

  always_comb begin
    if (cmd.load) begin
      j_nxt = '0;
    end else if (cmd.adv) begin
      j_nxt = j_r + LW'(1);
    end else begin
      j_nxt = j_r;
    end
  end

  // source addresses never wrap: src + j < start + len <= depth on a valid phrase
  assign rd_addr  = src_r + AW'(j_nxt);
  assign wr_addr  = start_r + AW'(j_r);
  assign self_ref = (src_r + AW'(j_r)) >= start_r;
  assign h_src    = fwd_r ? fwd_val_r : rdata_r;
  assign h_cpy    = (self_ref || (h_src == 16'hFFFF)) ? h_src : h_src + 16'd1;

  // height store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      mem[wr_addr] <= h_cpy;
    end else if (cmd.lit) begin
      mem[wr_addr] <= 16'd0;
    end
    rdata_r <= mem[rd_addr];
  end

  // phrase registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_r    <= AW'(in_source_position);
      len_r    <= LW'(in_phrase_length);
      eot_r    <= in_end_of_text;
      status_r <= status_nxt;
      start_r  <= AW'(text_end_r);
    end
    j_r       <= j_nxt;
    fwd_val_r <= h_cpy;
    if (cmd.adv || cmd.lit || cmd.err) begin
      out_pos_r    <= cmd.err ? 16'(text_end_r) : 16'(wr_addr);
      out_height_r <= cmd.adv ? h_cpy : 16'd0;
      out_last_r   <= !cmd.adv;
      out_status_r <= cmd.err ? status_r : lzpht_pkg::ST_OK;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_end_r  <= '0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // bypass when the next read hits the entry written this cycle
      fwd_r <= cmd.adv && (rd_addr == wr_addr);
      if (cmd.lit) begin
        text_end_r <= eot_r ? '0 : TEW'(start_r) + TEW'(len_r);
      end else if (cmd.err && eot_r) begin
        text_end_r <= '0;
      end
      if (cmd.adv || cmd.lit || cmd.err) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.st_ok     = (status_r == lzpht_pkg::ST_OK);
  assign sts.is_lit    = (len_r == LW'(1));
  assign sts.last_copy = (j_r == len_r - LW'(2));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_text_position = out_pos_r;
  assign out_height        = out_height_r;
  assign out_last          = out_last_r;
  assign out_status        = out_status_r;

  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != lzpht_pkg::ST_OK)) |-> out_last_r)
    else $error("error result not marked last");

  a_text_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(text_end_r) <= CW'(TEXT_DEPTH))
    else $error("text end beyond store depth");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(cmd.adv))
    else $error("bypass without preceding store write");

endmodule
